/* rtl/swrs_pkg.sv */
// ----------------------------------------------------------------------------
// swrs_pkg: shared definitions for the sliding-window rank selector
// Default sizes, configuration register indices and the control word
// that travels with each candidate through the row of cells.
// ----------------------------------------------------------------------------
package swrs_pkg;

    // Default sizes for the top-level parameters.
    localparam int WINDOW_MAX_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;

    // Width of each configuration register.
    localparam int CFG_BITS = 7;

    // Configuration register indices.
    localparam logic REG_WINDOW_LENGTH = 1'b0;
    localparam logic REG_RANK          = 1'b1;

    // Control word of a candidate moving along the cell row.
    typedef struct packed {
        logic vld;   // a candidate occupies this stage
        logic last;  // final candidate of the current request
    } t_tok_ctl;

endpackage

/* rtl/swrs_cell.sv */
// ----------------------------------------------------------------------------
// swrs_cell: one cell of the rank-selection row
// Holds one window sample (cell IDX holds the IDX-th most recent sample),
// a feed copy that streams candidates towards the head of the row, and one
// stage of the candidate pipeline that counts smaller and not-greater values.
// ----------------------------------------------------------------------------
module swrs_cell #(
    parameter int IDX         = 0,
    parameter int SAMPLE_BITS = 16,
    parameter int CW          = 7
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // sample shift line
    input  logic                          i_shift,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic signed [SAMPLE_BITS-1:0] o_sample,
    // candidate feed, moving towards cell 0
    input  logic                          i_scan,
    input  logic signed [SAMPLE_BITS-1:0] i_feed,
    output logic signed [SAMPLE_BITS-1:0] o_feed,
    // effective window length
    input  logic        [CW-1:0]          i_len,
    // candidate pipeline
    input  swrs_pkg::t_tok_ctl            i_ctl,
    input  logic signed [SAMPLE_BITS-1:0] i_cand,
    input  logic        [CW-1:0]          i_lt,
    input  logic        [CW-1:0]          i_le,
    output swrs_pkg::t_tok_ctl            o_ctl,
    output logic signed [SAMPLE_BITS-1:0] o_cand,
    output logic        [CW-1:0]          o_lt,
    output logic        [CW-1:0]          o_le
);
    import swrs_pkg::*;

    logic signed [SAMPLE_BITS-1:0] r_value;
    logic signed [SAMPLE_BITS-1:0] r_feed;
    t_tok_ctl                      r_ctl;
    logic signed [SAMPLE_BITS-1:0] r_cand;
    logic        [CW-1:0]          r_lt;
    logic        [CW-1:0]          r_le;
    logic                          w_in_win;
    logic                          w_less;
    logic                          w_not_greater;

    // The sample and its feed copy load together; the feed then streams on.
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_value <= i_sample;
            r_feed  <= i_sample;
        end else if (i_scan) begin
            r_feed  <= i_feed;
        end
    end

    // Only cells inside the current window take part in the count.
    assign w_in_win      = CW'(IDX) < i_len;
    assign w_less        = w_in_win && (r_value < i_cand);
    assign w_not_greater = w_in_win && (r_value <= i_cand);

    // Candidate stage control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    // Candidate stage payload with updated counts.
    always_ff @(posedge i_clk) begin
        r_cand <= i_cand;
        r_lt   <= i_lt + CW'(w_less);
        r_le   <= i_le + CW'(w_not_greater);
    end

    assign o_sample = r_value;
    assign o_feed   = r_feed;
    assign o_ctl    = r_ctl;
    assign o_cand   = r_cand;
    assign o_lt     = r_lt;
    assign o_le     = r_le;

endmodule

/* rtl/sliding_window_rank_select.sv */
// ----------------------------------------------------------------------------
// sliding_window_rank_select: rank-order filter over a sliding window
// Keeps the most recent samples in a row of cells and reports the
// rank-th smallest of the last window_length samples, clipped at zero.
// ----------------------------------------------------------------------------
// Samples shift into a row of WINDOW_MAX cells, newest in cell 0. A request
// that fills the window starts a scan: the window's samples are fed one per
// cycle as candidates into the row, and each candidate collects, cell by cell,
// how many window samples are smaller and how many are not greater; the one
// whose counts bracket the rank is the result. A request is accepted, its
// window_length candidates are injected, the last candidate passes the row
// and the output register is loaded. The last step waits for as long as the
// output side stalls a previous result. A request that does not yet fill the
// window gives no result. A restart request empties the window before its
// sample is stored. A zero length or rank acts as one, a length above
// WINDOW_MAX acts as WINDOW_MAX and a rank above the length selects the
// largest value. Configuration must be written only while idle; the block
// does not enforce this.
module sliding_window_rank_select #(
    parameter int WINDOW_MAX  = swrs_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = swrs_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [swrs_pkg::CFG_BITS-1:0] i_cfg_data,
    // input requests
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_restart,
    // output requests
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [SAMPLE_BITS-1:0] o_beauty
);
    import swrs_pkg::*;

    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int EW = (CW > CFG_BITS) ? CW : CFG_BITS;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [CFG_BITS-1:0]          r_cfg_len;
    logic [CFG_BITS-1:0]          r_cfg_rank;
    logic [1:0]                   r_state;
    logic [1:0]                   n_state;
    logic [CW-1:0]                r_fill;
    logic [CW-1:0]                r_len;
    logic [CW-1:0]                r_rank;
    logic [CW-1:0]                r_inj;
    logic signed [SAMPLE_BITS-1:0] r_pick;
    logic                         r_out_vld;
    logic signed [SAMPLE_BITS-1:0] r_beauty;

    logic [EW-1:0]                w_len_ext;
    logic [EW-1:0]                w_rank_ext;
    logic [CW-1:0]                w_eff_len;
    logic [CW-1:0]                w_eff_rank;
    logic [CW-1:0]                w_fill_nx;
    logic                         w_accept;
    logic                         w_hit;
    logic                         w_scan;
    logic                         w_inj_last;
    logic                         w_load_out;
    logic                         w_match;

    logic signed [SAMPLE_BITS-1:0] w_val   [WINDOW_MAX];
    logic signed [SAMPLE_BITS-1:0] w_feed  [WINDOW_MAX];
    t_tok_ctl                      w_ctl   [WINDOW_MAX+1];
    logic signed [SAMPLE_BITS-1:0] w_cand  [WINDOW_MAX+1];
    logic [CW-1:0]                 w_lt    [WINDOW_MAX+1];
    logic [CW-1:0]                 w_le    [WINDOW_MAX+1];

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_len  <= CFG_BITS'(1);
            r_cfg_rank <= CFG_BITS'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_WINDOW_LENGTH: r_cfg_len  <= i_cfg_data;
                REG_RANK:          r_cfg_rank <= i_cfg_data;
                default:           ;
            endcase
        end
    end

    // Effective window length and rank after clamping.
    always_comb begin
        w_len_ext = EW'(r_cfg_len);
        if (w_len_ext == '0) begin
            w_len_ext = EW'(1);
        end
        if (w_len_ext > EW'(WINDOW_MAX)) begin
            w_len_ext = EW'(WINDOW_MAX);
        end
        w_eff_len  = CW'(w_len_ext);
        w_rank_ext = EW'(r_cfg_rank);
        if (w_rank_ext == '0) begin
            w_rank_ext = EW'(1);
        end
        if (w_rank_ext > w_len_ext) begin
            w_rank_ext = w_len_ext;
        end
        w_eff_rank = CW'(w_rank_ext);
    end

    // Input handshake and fill tracking.
    assign o_stall   = (r_state != ST_IDLE);
    assign w_accept  = i_valid && !o_stall;
    assign w_fill_nx = i_restart ? CW'(1)
                     : (r_fill == CW'(WINDOW_MAX)) ? r_fill : r_fill + CW'(1);
    assign w_hit     = (w_fill_nx >= w_eff_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (w_accept) begin
            r_fill <= w_fill_nx;
        end
    end

    // Length and rank are held for the whole scan.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_len  <= w_eff_len;
            r_rank <= w_eff_rank;
        end
    end

    // Candidate injection counter.
    assign w_scan     = (r_state == ST_SCAN);
    assign w_inj_last = (r_inj == r_len - CW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inj <= '0;
        end else if (w_accept) begin
            r_inj <= '0;
        end else if (w_scan) begin
            r_inj <= r_inj + CW'(1);
        end
    end

    // Head of the candidate pipeline.
    assign w_ctl[0].vld  = w_scan;
    assign w_ctl[0].last = w_scan && w_inj_last;
    assign w_cand[0]     = w_feed[0];
    assign w_lt[0]       = '0;
    assign w_le[0]       = '0;

    // Row of cells.
    for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
        logic signed [SAMPLE_BITS-1:0] w_shift_in;
        logic signed [SAMPLE_BITS-1:0] w_feed_in;

        if (g == 0) begin : g_head
            assign w_shift_in = i_sample;
        end else begin : g_body
            assign w_shift_in = w_val[g-1];
        end

        if (g == WINDOW_MAX - 1) begin : g_tail
            assign w_feed_in = '0;
        end else begin : g_inner
            assign w_feed_in = w_feed[g+1];
        end

        swrs_cell #(
            .IDX         (g),
            .SAMPLE_BITS (SAMPLE_BITS),
            .CW          (CW)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_shift  (w_accept),
            .i_sample (w_shift_in),
            .o_sample (w_val[g]),
            .i_scan   (w_scan),
            .i_feed   (w_feed_in),
            .o_feed   (w_feed[g]),
            .i_len    (r_len),
            .i_ctl    (w_ctl[g]),
            .i_cand   (w_cand[g]),
            .i_lt     (w_lt[g]),
            .i_le     (w_le[g]),
            .o_ctl    (w_ctl[g+1]),
            .o_cand   (w_cand[g+1]),
            .o_lt     (w_lt[g+1]),
            .o_le     (w_le[g+1])
        );
    end

    // A candidate is the rank-th smallest when fewer than rank values lie
    // below it and at least rank values are not above it.
    assign w_match = w_ctl[WINDOW_MAX].vld
                  && (w_lt[WINDOW_MAX] < r_rank)
                  && (r_rank <= w_le[WINDOW_MAX]);

    always_ff @(posedge i_clk) begin
        if (w_match) begin
            r_pick <= w_cand[WINDOW_MAX];
        end
    end

    // Request sequencing.
    assign w_load_out = (r_state == ST_DONE) && (!r_out_vld || !i_stall);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && w_hit) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_inj_last) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (w_ctl[WINDOW_MAX].vld && w_ctl[WINDOW_MAX].last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Output register; positive picks are clipped to zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_load_out) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_beauty <= (!r_pick[SAMPLE_BITS-1] && (r_pick != '0)) ? '0 : r_pick;
        end
    end

    assign o_valid  = r_out_vld;
    assign o_beauty = r_beauty;

    // The final candidate leaving the row always ends the scan.
    a_last_ends_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl[WINDOW_MAX].vld && w_ctl[WINDOW_MAX].last) |=> (r_state == ST_DONE))
        else $error("final candidate did not complete the request");

    // Candidates only reach the end of the row while a request is in work.
    a_tail_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl[WINDOW_MAX].vld |-> (r_state == ST_SCAN || r_state == ST_WAIT))
        else $error("candidate left the row outside a request");

    // Injection never runs past the window.
    a_inj_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_inj < r_len))
        else $error("candidate injected beyond the window");

    // A delivered result is never positive.
    a_result_clipped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_beauty[SAMPLE_BITS-1] || (o_beauty == '0)))
        else $error("positive result delivered");

endmodule
